// ===== src/rc4ks_pkg.sv =====
// Shared constants, codes and controller/datapath types for the RC4 keystream generator.
package rc4ks_pkg;

	localparam int KEY_DEPTH = 256;
	localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int PERM_DEPTH = 256;
	localparam int PERM_AW = 8;
	localparam int BYTE_W = 8;
	localparam int FUNC_W = 2;
	localparam int BITCNT_W = 4;
	localparam int CFG_W = 9;

	localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_NEXT = 2'd2;

	localparam logic [PERM_AW-1:0] PERM_LAST = 8'hFF;
	localparam logic [CFG_W-1:0] KEY_LEN_RESET = 9'd1;

	typedef enum logic [3:0] {
		OP_NONE   = 4'd0,
		OP_KEY_WR = 4'd1,
		OP_START  = 4'd2,
		OP_NX_I   = 4'd3,
		OP_NX_J   = 4'd4,
		OP_NX_SW  = 4'd5,
		OP_NX_T   = 4'd6,
		OP_NX_OUT = 4'd7,
		OP_KS_RD  = 4'd8,
		OP_KS_J   = 4'd9,
		OP_KS_SW1 = 4'd10,
		OP_KS_SW2 = 4'd11
	} dp_op_t;

	typedef struct packed {
		logic k_last;
		logic out_busy;
	} dp_status_t;

endpackage

// ===== src/rc4ks_stream_if.sv =====
// Valid/ready channel interfaces for the command and keystream transactions.
interface rc4ks_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [rc4ks_pkg::FUNC_W-1:0]      func;
	logic [7:0]                        key_index;
	logic [rc4ks_pkg::BYTE_W-1:0]      key_byte;
	logic [rc4ks_pkg::BITCNT_W-1:0]    bit_count;

	modport source (output valid, func, key_index, key_byte, bit_count, input ready);
	modport sink (input valid, func, key_index, key_byte, bit_count, output ready);
endinterface

interface rc4ks_ks_if;
	logic                              valid;
	logic                              ready;
	logic [rc4ks_pkg::BYTE_W-1:0]      keystream_byte;

	modport source (output valid, keystream_byte, input ready);
	modport sink (input valid, keystream_byte, output ready);
endinterface

// ===== src/rc4ks_ctrl.sv =====
// Sequencing state machine for key loading, key scheduling and keystream generation.
module rc4ks_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [rc4ks_pkg::FUNC_W-1:0] in_func,
	output logic                         in_ready,
	output rc4ks_pkg::dp_op_t            op,
	input  rc4ks_pkg::dp_status_t        sts
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_NX_J   = 9'b000000010,
		ST_NX_SW  = 9'b000000100,
		ST_NX_T   = 9'b000001000,
		ST_NX_OUT = 9'b000010000,
		ST_KS_RD  = 9'b000100000,
		ST_KS_J   = 9'b001000000,
		ST_KS_SW1 = 9'b010000000,
		ST_KS_SW2 = 9'b100000000
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		op = rc4ks_pkg::OP_NONE;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_func)
						rc4ks_pkg::FUNC_LOAD: begin
							op = rc4ks_pkg::OP_KEY_WR;
						end
						rc4ks_pkg::FUNC_START: begin
							op = rc4ks_pkg::OP_START;
							state_d = ST_KS_RD;
						end
						rc4ks_pkg::FUNC_NEXT: begin
							op = rc4ks_pkg::OP_NX_I;
							state_d = ST_NX_J;
						end
						default: begin
							op = rc4ks_pkg::OP_NONE;
						end
					endcase
				end
			end
			ST_NX_J: begin
				op = rc4ks_pkg::OP_NX_J;
				state_d = ST_NX_SW;
			end
			ST_NX_SW: begin
				op = rc4ks_pkg::OP_NX_SW;
				state_d = ST_NX_T;
			end
			ST_NX_T: begin
				op = rc4ks_pkg::OP_NX_T;
				state_d = ST_NX_OUT;
			end
			ST_NX_OUT: begin
				if (!sts.out_busy) begin
					op = rc4ks_pkg::OP_NX_OUT;
					state_d = ST_IDLE;
				end
			end
			ST_KS_RD: begin
				op = rc4ks_pkg::OP_KS_RD;
				state_d = ST_KS_J;
			end
			ST_KS_J: begin
				op = rc4ks_pkg::OP_KS_J;
				state_d = ST_KS_SW1;
			end
			ST_KS_SW1: begin
				op = rc4ks_pkg::OP_KS_SW1;
				state_d = ST_KS_SW2;
			end
			ST_KS_SW2: begin
				op = rc4ks_pkg::OP_KS_SW2;
				state_d = sts.k_last ? ST_IDLE : ST_KS_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_next_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_func == rc4ks_pkg::FUNC_NEXT) |-> ##4 (state_q == ST_NX_OUT))
		else $error("Next transaction did not reach the output step in four cycles.");

	a_start_enters_schedule: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_func == rc4ks_pkg::FUNC_START) |=> (state_q == ST_KS_RD))
		else $error("Start transaction did not enter the key schedule.");

	a_schedule_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_KS_SW2 && !sts.k_last) |=> (state_q == ST_KS_RD && !in_ready))
		else $error("Key schedule ended before the last table entry.");

endmodule

// ===== src/rc4ks_dp.sv =====
// Datapath with the permutation table, key store, indices and keystream output register.
module rc4ks_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rc4ks_pkg::dp_op_t                 op,
	output rc4ks_pkg::dp_status_t             sts,
	input  logic [7:0]                        key_index,
	input  logic [rc4ks_pkg::BYTE_W-1:0]      key_byte,
	input  logic [rc4ks_pkg::BITCNT_W-1:0]    bit_count,
	input  logic                              cfg_we,
	input  logic [rc4ks_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                              ks_ready,
	output logic                              ks_valid,
	output logic [rc4ks_pkg::BYTE_W-1:0]      ks_byte
);

	logic [rc4ks_pkg::BYTE_W-1:0]     perm_mem [rc4ks_pkg::PERM_DEPTH];
	logic [rc4ks_pkg::BYTE_W-1:0]     key_mem [rc4ks_pkg::KEY_DEPTH];
	logic [rc4ks_pkg::PERM_DEPTH-1:0] perm_vld_q;

	logic [rc4ks_pkg::BYTE_W-1:0]     perm_rd_q;
	logic                             perm_rv_q;
	logic [rc4ks_pkg::PERM_AW-1:0]    perm_raddr_q;
	logic [rc4ks_pkg::BYTE_W-1:0]     perm_rdata;
	logic                             perm_re;
	logic [rc4ks_pkg::PERM_AW-1:0]    perm_ra;
	logic                             perm_we;
	logic [rc4ks_pkg::PERM_AW-1:0]    perm_wa;
	logic [rc4ks_pkg::BYTE_W-1:0]     perm_wd;

	logic [rc4ks_pkg::BYTE_W-1:0]     key_rd_q;
	logic                             key_we;

	logic [rc4ks_pkg::PERM_AW-1:0]    i_q;
	logic [rc4ks_pkg::PERM_AW-1:0]    j_q;
	logic [rc4ks_pkg::PERM_AW-1:0]    k_q;
	logic [rc4ks_pkg::KEY_AW-1:0]     kc_q;
	logic [rc4ks_pkg::BYTE_W-1:0]     si_q;
	logic [rc4ks_pkg::BYTE_W-1:0]     sj_q;
	logic                             fwd_q;
	logic [rc4ks_pkg::BITCNT_W-1:0]   bc_q;
	logic [rc4ks_pkg::CFG_W-1:0]      key_len_q;
	logic [rc4ks_pkg::CFG_W-1:0]      len_eff;
	logic [rc4ks_pkg::CFG_W-1:0]      kc_nx;

	logic [rc4ks_pkg::PERM_AW-1:0]    i_inc;
	logic [rc4ks_pkg::PERM_AW-1:0]    j_nx_gen;
	logic [rc4ks_pkg::PERM_AW-1:0]    j_nx_sched;
	logic [rc4ks_pkg::PERM_AW-1:0]    t_addr;
	logic [rc4ks_pkg::BYTE_W-1:0]     out_mask;
	logic [rc4ks_pkg::BYTE_W-1:0]     out_val;

	logic                             ks_valid_q;
	logic [rc4ks_pkg::BYTE_W-1:0]     ks_byte_q;

	// An entry not written since reset or the last start reads as its own index.
	assign perm_rdata = perm_rv_q ? perm_rd_q : perm_raddr_q;

	assign i_inc = i_q + 8'd1;
	assign j_nx_gen = j_q + perm_rdata;
	assign j_nx_sched = j_q + perm_rdata + key_rd_q;
	assign t_addr = si_q + sj_q;

	always_comb begin
		if (key_len_q == '0) begin
			len_eff = rc4ks_pkg::CFG_W'(1);
		end else if (key_len_q > rc4ks_pkg::CFG_W'(rc4ks_pkg::KEY_DEPTH)) begin
			len_eff = rc4ks_pkg::CFG_W'(rc4ks_pkg::KEY_DEPTH);
		end else begin
			len_eff = key_len_q;
		end
	end

	assign kc_nx = rc4ks_pkg::CFG_W'(kc_q) + rc4ks_pkg::CFG_W'(1);

	always_comb begin
		for (int b = 0; b < rc4ks_pkg::BYTE_W; b++) begin
			out_mask[b] = (bc_q > rc4ks_pkg::BITCNT_W'(b));
		end
	end

	assign out_val = (fwd_q ? si_q : perm_rdata) & out_mask;

	always_comb begin
		perm_re = 1'b0;
		perm_ra = k_q;
		perm_we = 1'b0;
		perm_wa = k_q;
		perm_wd = perm_rdata;
		case (op)
			rc4ks_pkg::OP_NX_I: begin
				perm_re = 1'b1;
				perm_ra = i_inc;
			end
			rc4ks_pkg::OP_NX_J: begin
				perm_re = 1'b1;
				perm_ra = j_nx_gen;
			end
			rc4ks_pkg::OP_NX_SW: begin
				perm_we = 1'b1;
				perm_wa = i_q;
				perm_wd = perm_rdata;
			end
			rc4ks_pkg::OP_NX_T: begin
				perm_we = 1'b1;
				perm_wa = j_q;
				perm_wd = si_q;
				perm_re = 1'b1;
				perm_ra = t_addr;
			end
			rc4ks_pkg::OP_KS_RD: begin
				perm_re = 1'b1;
				perm_ra = k_q;
			end
			rc4ks_pkg::OP_KS_J: begin
				perm_re = 1'b1;
				perm_ra = j_nx_sched;
			end
			rc4ks_pkg::OP_KS_SW1: begin
				perm_we = 1'b1;
				perm_wa = k_q;
				perm_wd = perm_rdata;
			end
			rc4ks_pkg::OP_KS_SW2: begin
				perm_we = 1'b1;
				perm_wa = j_q;
				perm_wd = si_q;
			end
			default: begin
				perm_re = 1'b0;
			end
		endcase
	end

	assign key_we = (op == rc4ks_pkg::OP_KEY_WR)
		&& ({1'b0, key_index} < rc4ks_pkg::CFG_W'(rc4ks_pkg::KEY_DEPTH));

	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[perm_wa] <= perm_wd;
		end
		if (perm_re) begin
			perm_rd_q <= perm_mem[perm_ra];
			perm_rv_q <= perm_vld_q[perm_ra];
			perm_raddr_q <= perm_ra;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_vld_q <= '0;
		end else if (op == rc4ks_pkg::OP_START) begin
			perm_vld_q <= '0;
		end else if (perm_we) begin
			perm_vld_q[perm_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_index[rc4ks_pkg::KEY_AW-1:0]] <= key_byte;
		end
		if (op == rc4ks_pkg::OP_KS_RD) begin
			key_rd_q <= key_mem[kc_q];
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			rc4ks_pkg::OP_NX_I: begin
				bc_q <= bit_count;
			end
			rc4ks_pkg::OP_NX_J: begin
				si_q <= perm_rdata;
			end
			rc4ks_pkg::OP_NX_SW: begin
				sj_q <= perm_rdata;
			end
			rc4ks_pkg::OP_NX_T: begin
				fwd_q <= (t_addr == j_q);
			end
			rc4ks_pkg::OP_KS_J: begin
				si_q <= perm_rdata;
			end
			rc4ks_pkg::OP_NX_OUT: begin
				ks_byte_q <= out_val;
			end
			default: begin
				fwd_q <= fwd_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			kc_q <= '0;
			key_len_q <= rc4ks_pkg::KEY_LEN_RESET;
			ks_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				key_len_q <= cfg_wdata;
			end
			if (op == rc4ks_pkg::OP_NX_OUT) begin
				ks_valid_q <= 1'b1;
			end else if (ks_ready) begin
				ks_valid_q <= 1'b0;
			end
			case (op)
				rc4ks_pkg::OP_START: begin
					j_q <= '0;
					k_q <= '0;
					kc_q <= '0;
				end
				rc4ks_pkg::OP_NX_I: begin
					i_q <= i_inc;
				end
				rc4ks_pkg::OP_NX_J: begin
					j_q <= j_nx_gen;
				end
				rc4ks_pkg::OP_KS_J: begin
					j_q <= j_nx_sched;
				end
				rc4ks_pkg::OP_KS_SW2: begin
					k_q <= k_q + 8'd1;
					if (kc_nx >= len_eff) begin
						kc_q <= '0;
					end else begin
						kc_q <= kc_nx[rc4ks_pkg::KEY_AW-1:0];
					end
					if (k_q == rc4ks_pkg::PERM_LAST) begin
						i_q <= '0;
						j_q <= '0;
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	assign ks_valid = ks_valid_q;
	assign ks_byte = ks_byte_q;
	assign sts.k_last = (k_q == rc4ks_pkg::PERM_LAST);
	assign sts.out_busy = ks_valid_q && !ks_ready;

endmodule

// ===== src/stream_cipher_keystream_generator_top.sv =====
// Top level of the RC4 keystream generator.
// The block takes one command transaction at a time. A load transaction writes one key byte
// and is done in its accept cycle. A start transaction resets the permutation to the identity
// and runs the key schedule, stepping each table entry through the read, j-update and
// swap-write states, before the next command is taken. A next transaction steps through the
// i read, j read, swap and output states, the output state waiting while the previous byte
// still waits at the output; the next command is taken only after the byte is registered.
// Each step makes three reads and two swap writes; the table has one read and one write port.
// The user must write key_length only while the block is idle; the block does not enforce it.
module stream_cipher_keystream_generator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	rc4ks_cmd_if.sink                   cmd,
	rc4ks_ks_if.source                  ks,
	input  logic                        cfg_we,
	input  logic [rc4ks_pkg::CFG_W-1:0] cfg_wdata
);

	rc4ks_pkg::dp_op_t     op;
	rc4ks_pkg::dp_status_t sts;
	logic                  cmd_ready;
	logic                  ks_valid;
	logic [7:0]            ks_byte;

	rc4ks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_func  (cmd.func),
		.in_ready (cmd_ready),
		.op       (op),
		.sts      (sts)
	);

	rc4ks_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.sts       (sts),
		.key_index (cmd.key_index),
		.key_byte  (cmd.key_byte),
		.bit_count (cmd.bit_count),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ks_ready  (ks.ready),
		.ks_valid  (ks_valid),
		.ks_byte   (ks_byte)
	);

	assign cmd.ready = cmd_ready;
	assign ks.valid = ks_valid;
	assign ks.keystream_byte = ks_byte;

endmodule
